FILE: hdl/assert_macros.svh
// Assertion macros shared by the region bin tiler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds in the same cycle as ante.
`define RBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that cons holds in the cycle after ante.
`define RBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rbt_pkg.sv
// Shared widths and control types of the region bin tiler.
`default_nettype none

package rbt_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int WIDTH_BITS = 48;
    localparam int IDX_BITS   = 32;
    localparam int ACC_BITS   = WIDTH_BITS + IDX_BITS;
    localparam int GRID_BITS  = COORD_BITS + 1;

    // Commands to the width-times-index accumulator.
    typedef struct packed {
        logic init;   // load the width itself (index one)
        logic step;   // add one more width (index grows by one)
        logic run;    // rebuild the product bit-serially from the index
    } t_scale_ctl;

endpackage

`default_nettype wire

FILE: hdl/region_bin_tiler.sv
// Top level of the region bin tiler: word handshakes, bin sequencer and state.
// Load word: without grid snapping it completes on accept; with it, the block waits on the
// 32-step serial remainder. Next word: ST_CALC and ST_ADJ, then ST_EMIT registers the result
// once the output register is free, and ST_FIN returns to ready. After a bin width write, the
// next bin first runs the bit-serial width-times-index rebuild; with no region, ST_ZERO answers.
// Reset (synchronous, active low) restores default registers; no region is loaded.
`default_nettype none

`include "assert_macros.svh"

module region_bin_tiler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // region_first[32:0], region_last[65:33], zero pad
    input  logic [0:0]  s_axis_tuser,   // op[0]
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // bin_start[31:0], bin_end[63:32]
    output logic [2:0]  m_axis_tuser,   // has_bin[0], bin_strand[2:1]
    // Register writes.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);

    localparam int CB = rbt_pkg::COORD_BITS;
    localparam int FB = rbt_pkg::FRAC_BITS;
    localparam int WB = rbt_pkg::WIDTH_BITS;
    localparam int GB = rbt_pkg::GRID_BITS;
    localparam int MB = 38;   // signed drift term: coordinates plus a 36-bit product

    localparam logic [0:0] OP_LOAD = 1'b0;
    localparam logic [0:0] OP_NEXT = 1'b1;

    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_OVERLAP = 2'd1;
    localparam logic [1:0] CFG_GRID    = 2'd2;
    localparam logic [1:0] CFG_STRANDS = 2'd3;

    localparam logic [1:0] STRAND_NONE  = 2'd0;
    localparam logic [1:0] STRAND_PLUS  = 2'd1;
    localparam logic [1:0] STRAND_MINUS = 2'd2;

    localparam logic [WB-1:0] WIDTH_RESET = WB'(1000 * (1 << FB));
    localparam logic [FB-1:0] HALF_UNIT   = FB'(1 << (FB - 1));
    localparam logic [CB-1:0] COORD_MAX   = '1;
    localparam logic [rbt_pkg::IDX_BITS-1:0] IDX_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_CALC,
        ST_ADJ,
        ST_EMIT,
        ST_FIN,
        ST_ZERO
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [WB-1:0]        r_width;
    logic signed [31:0]   r_ovl;
    logic                 r_grid;
    logic                 r_two;

    // Tiling state.
    logic                 r_active;
    logic [CB-1:0]        r_pos;
    logic [rbt_pkg::IDX_BITS-1:0] r_idx;
    logic                 r_minus;
    logic [CB-1:0]        r_origin;
    logic signed [32:0]   r_limit;
    logic                 r_dirty;    // accumulator no longer equals width times index

    // Bin computation pipeline registers.
    logic signed [MB-1:0] r_m;
    logic signed [CB+1:0] r_e0;
    logic [FB-1:0]        r_frac;
    logic                 r_big;
    logic [CB-1:0]        r_e;

    // Output register.
    logic                 r_out_valid;
    logic                 r_out_has;
    logic [CB-1:0]        r_out_start;
    logic [CB-1:0]        r_out_end;
    logic [1:0]           r_out_strand;

    // Input word fields.
    logic [0:0]           in_op;
    logic signed [32:0]   in_first;
    logic signed [32:0]   in_last;
    logic                 in_acc;
    logic                 out_free;

    assign in_op    = s_axis_tuser;
    assign in_first = s_axis_tdata[32:0];
    assign in_last  = s_axis_tdata[65:33];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    // The output register takes a new word when empty or being drained.
    assign out_free      = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Region load. A negative start becomes one. The snapping grid is the
    // floor of width minus overlap, at least one; the snapped start is the
    // start minus its remainder by the grid, plus one.
    // ------------------------------------------------------------------
    logic [CB-1:0]        load_start;
    logic signed [WB+1:0] grid_d;
    logic signed [GB:0]   grid_g;
    logic [GB-1:0]        grid_div;
    logic                 div_done;
    logic [GB-1:0]        div_rem;
    logic [CB+1:0]        snap_sum;
    logic [CB-1:0]        snap_start;

    assign load_start = in_first[32] ? CB'(1) : in_first[CB-1:0];
    assign grid_d     = $signed({2'b00, r_width})
                      - $signed({{2{r_ovl[31]}}, r_ovl, {FB{1'b0}}});
    // Arithmetic shift gives the floor for negative differences as well.
    assign grid_g     = grid_d[WB+1:FB];
    assign grid_div   = (grid_g < $signed((GB+1)'(1))) ? GB'(1) : grid_g[GB-1:0];
    assign snap_sum   = {2'b00, r_pos} - {1'b0, div_rem} + (CB+2)'(1);
    assign snap_start = (snap_sum[CB+1:CB] != 2'b00) ? COORD_MAX : snap_sum[CB-1:0];

    rbt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_acc && (in_op == OP_LOAD) && r_grid),
        .i_dividend (load_start),
        .i_divisor  (grid_div),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // ------------------------------------------------------------------
    // Width times bin index. It is kept current by adding one width per
    // advance; a width write marks it stale and the next bin rebuilds it.
    // ------------------------------------------------------------------
    rbt_pkg::t_scale_ctl        scale_ctl;
    logic [rbt_pkg::ACC_BITS-1:0] scale_acc;
    logic                       scale_done;
    logic                       emit_adv;

    assign emit_adv = !r_two || r_minus;

    always_comb begin
        scale_ctl.init = in_acc && (in_op == OP_LOAD);
        scale_ctl.run  = in_acc && (in_op == OP_NEXT) && r_active && r_dirty;
        scale_ctl.step = (r_state == ST_EMIT) && out_free && emit_adv && (r_idx != IDX_MAX);
    end

    rbt_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scale_ctl),
        .i_width (r_width),
        .i_index (r_idx),
        .o_acc   (scale_acc),
        .o_done  (scale_done)
    );

    // ------------------------------------------------------------------
    // Bin end. The plain end is position - 1 + floor(width). The drift term
    // m = origin - 1 - end + floor(width * index) says how far the ideal end
    // lies from it; together with the fraction bits it moves the end by one
    // when the drift reaches half a unit. A product at or beyond 2^36 is far
    // past any coordinate and always moves the end up.
    // ------------------------------------------------------------------
    logic [CB-1:0]        wi;
    logic signed [CB+1:0] calc_e0;
    logic signed [MB-1:0] calc_m;
    logic                 calc_big;

    assign wi       = r_width[WB-1:FB];
    assign calc_e0  = $signed({2'b00, r_pos}) + $signed({2'b00, wi}) - (CB+2)'(1);
    assign calc_m   = $signed({6'd0, r_origin}) - $signed({6'd0, r_pos})
                    - $signed({6'd0, wi}) + $signed({2'b00, scale_acc[FB+35:FB]});
    assign calc_big = |scale_acc[rbt_pkg::ACC_BITS-1:FB+36];

    logic                 adj_inc;
    logic                 adj_dec;
    logic signed [CB+2:0] adj_e1;
    logic signed [CB+2:0] adj_raised;
    logic [CB-1:0]        adj_e;

    always_comb begin
        adj_inc = r_big || (!r_m[MB-1] && (r_m != '0))
                || ((r_m == '0) && (r_frac >= HALF_UNIT));
        adj_dec = !adj_inc && ((r_m[MB-1] && (r_m != -MB'(1)))
                || ((r_m == -MB'(1)) && (r_frac <= HALF_UNIT)));
        adj_e1  = (CB+3)'(r_e0) + (adj_inc ? (CB+3)'(1) : '0) - (adj_dec ? (CB+3)'(1) : '0);
        // The end never falls below the bin start, then saturates.
        if (adj_e1 < $signed({3'b000, r_pos})) begin
            adj_raised = $signed({3'b000, r_pos});
        end else begin
            adj_raised = adj_e1;
        end
        adj_e = (adj_raised[CB+2:CB] != 3'b000) ? COORD_MAX : adj_raised[CB-1:0];
    end

    // ------------------------------------------------------------------
    // Advance: the next start is end + 1 - overlap, but at least one past the
    // current start, saturated to the coordinate range.
    // ------------------------------------------------------------------
    logic signed [CB+2:0] emit_s;
    logic signed [CB+2:0] emit_np;
    logic [CB-1:0]        emit_pos;
    logic [1:0]           emit_strand;
    logic                 fin_done;

    always_comb begin
        emit_s = $signed({3'b000, r_e}) + (CB+3)'(1) - $signed({{3{r_ovl[31]}}, r_ovl});
        if (emit_s > $signed({3'b000, r_pos})) begin
            emit_np = emit_s;
        end else begin
            emit_np = $signed({3'b000, r_pos}) + (CB+3)'(1);
        end
        emit_pos = (emit_np[CB+2:CB] != 3'b000) ? COORD_MAX : emit_np[CB-1:0];
        if (!r_two) begin
            emit_strand = STRAND_NONE;
        end else if (r_minus) begin
            emit_strand = STRAND_MINUS;
        end else begin
            emit_strand = STRAND_PLUS;
        end
    end

    // A positive limit ends the region once the start has passed it.
    assign fin_done = !r_limit[32] && (r_limit != '0) && ({1'b0, r_pos} > r_limit[32:0]);

    // ------------------------------------------------------------------
    // Sequencer, state and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_width      <= WIDTH_RESET;
            r_ovl        <= '0;
            r_grid       <= 1'b0;
            r_two        <= 1'b0;
            r_active     <= 1'b0;
            r_pos        <= '0;
            r_idx        <= rbt_pkg::IDX_BITS'(1);
            r_minus      <= 1'b0;
            r_origin     <= '0;
            r_limit      <= '0;
            r_dirty      <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (in_op == OP_LOAD) begin
                            r_pos    <= load_start;
                            r_origin <= load_start;
                            r_limit  <= in_last;
                            r_idx    <= rbt_pkg::IDX_BITS'(1);
                            r_minus  <= 1'b0;
                            r_active <= 1'b1;
                            r_dirty  <= 1'b0;
                            r_state  <= r_grid ? ST_DIV : ST_IDLE;
                        end else if (!r_active) begin
                            r_state <= ST_ZERO;
                        end else if (r_dirty) begin
                            r_state <= ST_MUL;
                        end else begin
                            r_state <= ST_CALC;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_pos    <= snap_start;
                        r_origin <= snap_start;
                        r_state  <= ST_IDLE;
                    end
                end
                ST_MUL: begin
                    if (scale_done) begin
                        r_dirty <= 1'b0;
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_e0    <= calc_e0;
                    r_m     <= calc_m;
                    r_frac  <= scale_acc[FB-1:0];
                    r_big   <= calc_big;
                    r_state <= ST_ADJ;
                end
                ST_ADJ: begin
                    r_e     <= adj_e;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_has    <= 1'b1;
                        r_out_start  <= r_pos;
                        r_out_end    <= r_e;
                        r_out_strand <= emit_strand;
                        if (r_two) begin
                            r_minus <= !r_minus;
                        end
                        if (emit_adv) begin
                            r_pos <= emit_pos;
                            if (r_idx != IDX_MAX) begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (fin_done) begin
                        r_active <= 1'b0;
                    end
                    r_state <= ST_IDLE;
                end
                ST_ZERO: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_has    <= 1'b0;
                        r_out_start  <= '0;
                        r_out_end    <= '0;
                        r_out_strand <= STRAND_NONE;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // The user must change registers only while the block is idle; the block itself does not enforce it.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_WIDTH: begin
                        r_width <= i_cfg_data;
                        r_dirty <= 1'b1;
                    end
                    CFG_OVERLAP: r_ovl  <= i_cfg_data[31:0];
                    CFG_GRID:    r_grid <= i_cfg_data[0];
                    CFG_STRANDS: r_two  <= i_cfg_data[0];
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_end, r_out_start};
    assign m_axis_tuser  = {r_out_strand, r_out_has};

    `RBT_ASSERT_NOW(a_bin_order, i_clk, i_rst_n, r_out_valid && r_out_has, r_out_end >= r_out_start, "bin end below bin start")
    `RBT_ASSERT_NOW(a_nobin_zero, i_clk, i_rst_n, r_out_valid && !r_out_has, (r_out_start == '0) && (r_out_end == '0) && (r_out_strand == STRAND_NONE), "no-bin word carries data")
    `RBT_ASSERT_NEXT(a_load_active, i_clk, i_rst_n, in_acc && (in_op == OP_LOAD), r_active, "load did not open a region")
    `RBT_ASSERT_NOW(a_mul_stale, i_clk, i_rst_n, r_state == ST_MUL, r_dirty, "rebuild without a width change")

endmodule

`default_nettype wire

FILE: hdl/rbt_divider.sv
// Bit-serial restoring remainder unit used for grid snapping.
`default_nettype none

`include "assert_macros.svh"

module rbt_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rbt_pkg::COORD_BITS-1:0] i_dividend,
    input  logic [rbt_pkg::GRID_BITS-1:0]  i_divisor,
    output logic                           o_done,
    output logic [rbt_pkg::GRID_BITS-1:0]  o_rem
);

    localparam int CNT_BITS = $clog2(rbt_pkg::COORD_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(rbt_pkg::COORD_BITS - 1);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_BITS-1:0]            r_cnt;
    logic [rbt_pkg::COORD_BITS-1:0] r_quo;
    logic [rbt_pkg::GRID_BITS-1:0]  r_rem;
    logic [rbt_pkg::GRID_BITS-1:0]  r_div;

    logic [rbt_pkg::GRID_BITS:0]    trial;
    logic                           fits;

    // One dividend bit enters the partial remainder each cycle while the unit is busy.
    assign trial = {r_rem, r_quo[rbt_pkg::COORD_BITS-1]};
    assign fits  = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[rbt_pkg::COORD_BITS-2:0], 1'b0};
                if (fits) begin
                    r_rem <= rbt_pkg::GRID_BITS'(trial - {1'b0, r_div});
                end else begin
                    r_rem <= trial[rbt_pkg::GRID_BITS-1:0];
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    `RBT_ASSERT_NOW(a_rem_below_div, i_clk, i_rst_n, r_done, r_rem < r_div, "remainder not below divisor")

endmodule

`default_nettype wire

FILE: hdl/rbt_scale.sv
// Accumulator holding bin width times bin index, with a bit-serial rebuild.
`default_nettype none

module rbt_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rbt_pkg::t_scale_ctl            i_ctl,
    input  logic [rbt_pkg::WIDTH_BITS-1:0] i_width,
    input  logic [rbt_pkg::IDX_BITS-1:0]   i_index,
    output logic [rbt_pkg::ACC_BITS-1:0]   o_acc,
    output logic                           o_done
);

    localparam int CNT_BITS = $clog2(rbt_pkg::IDX_BITS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(rbt_pkg::IDX_BITS - 1);

    logic                           r_busy;
    logic                           r_done;
    logic [CNT_BITS-1:0]            r_cnt;
    logic [rbt_pkg::ACC_BITS-1:0]   r_acc;

    logic [rbt_pkg::WIDTH_BITS:0]   part_sum;

    // Shift-and-add: the low half holds the remaining index bits, the high
    // half collects the product and shifts down one bit per cycle while the rebuild runs.
    assign part_sum = {1'b0, r_acc[rbt_pkg::ACC_BITS-1:rbt_pkg::IDX_BITS]}
                    + (r_acc[0] ? {1'b0, i_width} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.init) begin
                r_acc <= {{rbt_pkg::IDX_BITS{1'b0}}, i_width};
            end else if (i_ctl.step) begin
                r_acc <= r_acc + {{rbt_pkg::IDX_BITS{1'b0}}, i_width};
            end else if (i_ctl.run) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= {{rbt_pkg::WIDTH_BITS{1'b0}}, i_index};
            end else if (r_busy) begin
                r_acc <= {part_sum, r_acc[rbt_pkg::IDX_BITS-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire
